>>> src/csvt_pkg.sv
// Shared types and constants for the CSV field tokenizer.
package csvt_pkg;

  // Character codes
  localparam logic [7:0] CH_QUOTE = 8'h22;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  // Row ending modes
  localparam logic [1:0] NL_UNIVERSAL = 2'd0;
  localparam logic [1:0] NL_LF        = 2'd1;
  localparam logic [1:0] NL_CR        = 2'd2;
  localparam logic [1:0] NL_CRLF      = 2'd3;

  // Error codes
  localparam logic [1:0] ERR_NONE        = 2'd0;
  localparam logic [1:0] ERR_TEXT_BEFORE = 2'd1;
  localparam logic [1:0] ERR_TEXT_AFTER  = 2'd2;
  localparam logic [1:0] ERR_UNEXP_END   = 2'd3;

  // Input commands
  localparam logic CMD_CHAR = 1'b0;
  localparam logic CMD_EOD  = 1'b1;

  // Register indexes
  localparam logic REG_EOL_MODE = 1'b0;

  // Field counting
  localparam int MAX_FIELDS = 256;
  localparam int FIELD_CAP  = (MAX_FIELDS - 1 > 255) ? 255 : MAX_FIELDS - 1;

  // Result queue
  localparam int QDEPTH = 4;
  localparam int QAW    = $clog2(QDEPTH);

  typedef enum logic [2:0] {
    PH_OPEN  = 3'b001,
    PH_INQ   = 3'b010,
    PH_AFTER = 3'b100
  } csvt_phase_t;

  typedef struct packed {
    csvt_phase_t phase;
    logic        has_text;
    logic        cr_pending;
    logic        skip_lf;
    logic [7:0]  fields;
  } csvt_state_t;

  localparam csvt_state_t ST_CLEAR = '{phase: PH_OPEN, has_text: 1'b0, cr_pending: 1'b0,
                                       skip_lf: 1'b0, fields: 8'd0};

  // One result word
  typedef struct packed {
    logic [7:0] data_char;
    logic       char_valid;
    logic       field_end;
    logic       row_end;
    logic [7:0] field_index;
    logic [1:0] error_code;
    logic       last;
  } csvt_res_t;

  // Words pushed into the queue in one cycle
  typedef struct packed {
    logic [1:0] n;
    csvt_res_t  r0;
    csvt_res_t  r1;
  } csvt_push_t;

  // Queue status
  typedef struct packed {
    logic           room;
    logic           nonempty;
    logic [QAW:0]   count;
  } csvt_qstat_t;

endpackage

>>> src/csv_field_tokenizer.sv
// Top level of the CSV field tokenizer: config register, front, queue and back.
//
//  channel | direction | handshake             | word
//  in      | input     | in_valid / in_stall   | command, char_code
//  out     | output    | out_valid / out_stall | data_char .. last
//  cfg     | APB write | psel penable pwrite   | row ending mode at byte address 0
//
// One character word is accepted per cycle while in_stall is low; it yields zero
// to two result words. The output port sends one word per cycle while out_stall
// is low, so the sustained rate is one item per cycle while items average at most
// one word; a four-word queue absorbs bursts. A result passes through the queue
// storage, then the output register. Reset is synchronous; no clearing pass
// follows. The input stalls when fewer than two queue slots are free.
module csv_field_tokenizer import csvt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_command,
  input  logic [7:0]  in_char_code,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_data_char,
  output logic        out_char_valid,
  output logic        out_field_end,
  output logic        out_row_end,
  output logic [7:0]  out_field_index,
  output logic [1:0]  out_error_code,
  output logic        out_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [1:0]  eol_mode_r, eol_mode_nxt;
  logic        cfg_wr;
  csvt_push_t  push;
  csvt_qstat_t qstat;
  csvt_res_t   head;
  csvt_res_t   out_res;
  logic        pop;

  // Configuration register
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_EOL_MODE);
  assign eol_mode_nxt = cfg_wr ? pwdata[1:0] : eol_mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) eol_mode_r <= NL_UNIVERSAL;
    else eol_mode_r <= eol_mode_nxt;
  end

  assign prdata = (paddr[2] == REG_EOL_MODE) ? {30'd0, eol_mode_r} : 32'd0;

  csvt_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_command   (in_command),
    .in_char_code (in_char_code),
    .eol_mode     (eol_mode_r),
    .room         (qstat.room),
    .in_stall     (in_stall),
    .push         (push)
  );

  csvt_queue u_queue (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .pop   (pop),
    .head  (head),
    .stat  (qstat)
  );

  csvt_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .nonempty  (qstat.nonempty),
    .out_stall (out_stall),
    .pop       (pop),
    .out_valid (out_valid),
    .out_res   (out_res)
  );

  assign out_data_char   = out_res.data_char;
  assign out_char_valid  = out_res.char_valid;
  assign out_field_end   = out_res.field_end;
  assign out_row_end     = out_res.row_end;
  assign out_field_index = out_res.field_index;
  assign out_error_code  = out_res.error_code;
  assign out_last        = out_res.last;

  // Checks
  a_queue_bound: assert property (@(posedge clk) disable iff (!rst_n)
    qstat.count <= (QAW+1)'(QDEPTH))
    else $error("result queue overfilled");

  a_push_needs_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (push.n != 2'd0) |-> (in_valid && !in_stall))
    else $error("words pushed without an accepted item");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (qstat.nonempty && !out_valid) |=> out_valid)
    else $error("queued word not moved to the output");

  a_row_with_field: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_row_end) |-> (out_field_end && !out_char_valid))
    else $error("row end without field end");

endmodule

>>> src/csvt_front.sv
// Front end: accepts characters, runs the parser state and forms result words.
module csvt_front import csvt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_command,
  input  logic [7:0]  in_char_code,
  input  logic [1:0]  eol_mode,
  input  logic        room,
  output logic        in_stall,
  output csvt_push_t  push
);

  typedef struct packed {
    csvt_state_t st;
    logic [1:0]  cnt;
    csvt_res_t   r0;
    csvt_res_t   r1;
  } csvt_acc_t;

  function automatic csvt_acc_t emit_res(csvt_acc_t a, logic [7:0] ch, logic v,
                                         logic fe, logic re, logic [1:0] err);
    csvt_acc_t o;
    csvt_res_t r;
    o = a;
    r.data_char   = v ? ch : 8'h00;
    r.char_valid  = v;
    r.field_end   = fe;
    r.row_end     = re;
    r.field_index = a.st.fields;
    r.error_code  = err;
    r.last        = 1'b0;
    case (a.cnt)
      2'd0: begin
        o.r0  = r;
        o.cnt = 2'd1;
      end
      2'd1: begin
        o.r1  = r;
        o.cnt = 2'd2;
      end
      default: o.cnt = a.cnt;
    endcase
    return o;
  endfunction

  function automatic csvt_acc_t end_field(csvt_acc_t a, logic row);
    csvt_acc_t o;
    o = emit_res(a, 8'h00, 1'b0, 1'b1, row, ERR_NONE);
    if (row) o.st.fields = 8'd0;
    else if (o.st.fields < 8'(FIELD_CAP)) o.st.fields = o.st.fields + 8'd1;
    o.st.phase    = PH_OPEN;
    o.st.has_text = 1'b0;
    return o;
  endfunction

  function automatic csvt_acc_t raise_error(csvt_acc_t a, logic [1:0] code);
    csvt_acc_t o;
    o    = emit_res(a, 8'h00, 1'b0, 1'b0, 1'b0, code);
    o.st = ST_CLEAR;
    return o;
  endfunction

  function automatic logic ends_row(logic [7:0] c, logic [1:0] mode);
    logic b;
    unique case (mode)
      NL_UNIVERSAL: b = (c == CH_CR) || (c == CH_LF);
      NL_LF:        b = (c == CH_LF);
      NL_CR:        b = (c == CH_CR);
      default:      b = 1'b0;
    endcase
    return b;
  endfunction

  // One byte through the parser; literal makes a CR plain data
  function automatic csvt_acc_t feed(csvt_acc_t a, logic [7:0] c, logic literal,
                                     logic [1:0] mode);
    csvt_acc_t o;
    logic      hold;
    logic      brk;
    o    = a;
    hold = !literal && (mode == NL_CRLF) && (c == CH_CR);
    brk  = !literal && ends_row(c, mode);
    unique case (a.st.phase)
      PH_INQ: begin
        if (c == CH_QUOTE) o.st.phase = PH_AFTER;
        else o = emit_res(a, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
      end
      PH_AFTER: begin
        if (c == CH_QUOTE) begin
          o = emit_res(a, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
          o.st.phase = PH_INQ;
        end else if (c == CH_COMMA) begin
          o = end_field(a, 1'b0);
        end else if (hold) begin
          o.st.cr_pending = 1'b1;
        end else if (brk) begin
          o = end_field(a, 1'b1);
          if (mode == NL_UNIVERSAL && c == CH_CR) o.st.skip_lf = 1'b1;
        end else begin
          o = raise_error(a, ERR_TEXT_AFTER);
        end
      end
      default: begin
        if (c == CH_QUOTE) begin
          if (a.st.has_text) o = raise_error(a, ERR_TEXT_BEFORE);
          else o.st.phase = PH_INQ;
        end else if (c == CH_COMMA) begin
          o = end_field(a, 1'b0);
        end else if (hold) begin
          o.st.cr_pending = 1'b1;
        end else if (brk) begin
          o = end_field(a, 1'b1);
          if (mode == NL_UNIVERSAL && c == CH_CR) o.st.skip_lf = 1'b1;
        end else begin
          o = emit_res(a, c, 1'b1, 1'b0, 1'b0, ERR_NONE);
          o.st.phase    = PH_OPEN;
          o.st.has_text = 1'b1;
        end
      end
    endcase
    return o;
  endfunction

  csvt_state_t st_r;
  csvt_state_t st_nxt;
  csvt_acc_t   acc;
  logic        accept;

  assign in_stall = !room;
  assign accept   = in_valid && !in_stall;

  // Per-item parse step
  always_comb begin
    acc.st  = st_r;
    acc.cnt = 2'd0;
    acc.r0  = '0;
    acc.r1  = '0;
    if (in_command == CMD_CHAR) begin
      if (acc.st.skip_lf && in_char_code == CH_LF) begin
        acc.st.skip_lf = 1'b0;
      end else begin
        acc.st.skip_lf = 1'b0;
        if (acc.st.cr_pending) begin
          acc.st.cr_pending = 1'b0;
          if (in_char_code == CH_LF) begin
            acc = end_field(acc, 1'b1);
          end else begin
            acc = feed(acc, CH_CR, 1'b1, eol_mode);
            acc = feed(acc, in_char_code, 1'b0, eol_mode);
          end
        end else begin
          acc = feed(acc, in_char_code, 1'b0, eol_mode);
        end
      end
    end else begin
      acc.st.skip_lf = 1'b0;
      if (acc.st.cr_pending) begin
        acc.st.cr_pending = 1'b0;
        acc = feed(acc, CH_CR, 1'b1, eol_mode);
      end
      if (acc.st.fields != 8'd0 || acc.st.phase == PH_INQ) acc = raise_error(acc, ERR_UNEXP_END);
      else acc.st = ST_CLEAR;
    end
    // mark the final word of this item
    if (acc.cnt == 2'd1) acc.r0.last = 1'b1;
    if (acc.cnt == 2'd2) acc.r1.last = 1'b1;
  end

  assign st_nxt = accept ? acc.st : st_r;

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= ST_CLEAR;
    else st_r <= st_nxt;
  end

  // Push words of an accepted item
  always_comb begin
    push.n  = accept ? acc.cnt : 2'd0;
    push.r0 = acc.r0;
    push.r1 = acc.r1;
  end

endmodule

>>> src/csvt_queue.sv
// Result word queue: up to two words in, one word out per cycle.
module csvt_queue import csvt_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  csvt_push_t  push,
  input  logic        pop,
  output csvt_res_t   head,
  output csvt_qstat_t stat
);

  csvt_res_t      mem_r [QDEPTH];
  logic [QAW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QAW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QAW:0]   count_r, count_nxt;
  logic [QAW-1:0] wr_ptr_p1;

  assign wr_ptr_p1  = wr_ptr_r + QAW'(1);
  assign wr_ptr_nxt = wr_ptr_r + QAW'(push.n);
  assign rd_ptr_nxt = rd_ptr_r + QAW'(pop);
  assign count_nxt  = count_r + (QAW+1)'(push.n) - (QAW+1)'(pop);

  // storage writes
  always_ff @(posedge clk) begin
    if (push.n != 2'd0) mem_r[wr_ptr_r] <= push.r0;
    if (push.n == 2'd2) mem_r[wr_ptr_p1] <= push.r1;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  assign head          = mem_r[rd_ptr_r];
  assign stat.room     = (count_r <= (QAW+1)'(QDEPTH - 2));
  assign stat.nonempty = (count_r != '0);
  assign stat.count    = count_r;

endmodule

>>> src/csvt_back.sv
// Back end: drains the queue into the registered result port.
module csvt_back import csvt_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  csvt_res_t  head,
  input  logic       nonempty,
  input  logic       out_stall,
  output logic       pop,
  output logic       out_valid,
  output csvt_res_t  out_res
);

  logic      out_valid_r, out_valid_nxt;
  csvt_res_t res_r;
  logic      load;

  assign load          = nonempty && (!out_valid_r || !out_stall);
  assign pop           = load;
  assign out_valid_nxt = load ? 1'b1 : (out_valid_r && out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else out_valid_r <= out_valid_nxt;
  end

  // payload holds while stalled
  always_ff @(posedge clk) begin
    if (load) res_r <= head;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule

>>> dv/csv_field_tokenizer_test.sv
// Self-checking testbench for the CSV field tokenizer: random rows, all row-ending modes.
`timescale 1ns / 1ps

module csv_field_tokenizer_test;
  import csvt_pkg::*;

  localparam int         QUIET_LIMIT = 2000;
  localparam int         DRAIN_WAIT  = 8;
  localparam logic [2:0] MODE_ADDR   = 3'(REG_EOL_MODE) << 2;

  // One input word as the sender sees it
  typedef struct packed {
    logic       command;
    logic [7:0] code;
  } csv_word_t;

  logic        clk;
  logic        rst_n          = 1'b0;
  logic        in_valid       = 1'b0;
  logic        in_stall;
  logic        in_command     = CMD_CHAR;
  logic [7:0]  in_char_code   = 8'd0;
  logic        out_valid;
  logic        out_stall      = 1'b0;
  logic [7:0]  out_data_char;
  logic        out_char_valid;
  logic        out_field_end;
  logic        out_row_end;
  logic [7:0]  out_field_index;
  logic [1:0]  out_error_code;
  logic        out_last;
  logic        psel           = 1'b0;
  logic        penable        = 1'b0;
  logic        pwrite         = 1'b0;
  logic [2:0]  paddr          = 3'd0;
  logic [31:0] pwdata         = 32'd0;
  logic [31:0] prdata;
  logic        pready;

  csv_word_t   char_feed[$];
  csvt_res_t   pending_results[$];
  csvt_res_t   step_words[$];
  int          mismatches     = 0;
  int          quiet_cycles   = 0;
  int          in_idle_pct    = 35;
  int          out_stall_pct  = 35;
  logic [1:0]  mode_seq [7]   = '{NL_LF, NL_CR, NL_UNIVERSAL, NL_CRLF,
                                  NL_UNIVERSAL, NL_CRLF, NL_LF};

  // Tokenizer state mirrored by the checker
  logic [1:0]  nl_mode        = NL_UNIVERSAL;
  csvt_phase_t ph             = PH_OPEN;
  logic        has_text       = 1'b0;
  logic        cr_held        = 1'b0;
  logic        lf_skip        = 1'b0;
  logic [7:0]  fld_cnt        = 8'd0;

  csv_field_tokenizer DUT (.*);

  always begin
    clk = 1'b1;
    #4;
    clk = 1'b0;
    #4;
  end

  // ---------------------------------------------------------------- predictor

  function automatic void put_word(logic [7:0] ch, logic vld, logic fe, logic re,
                                   logic [1:0] err);
    csvt_res_t w;
    if (step_words.size() >= 2) return;
    w.data_char   = vld ? ch : 8'd0;
    w.char_valid  = vld;
    w.field_end   = fe;
    w.row_end     = re;
    w.field_index = fld_cnt;
    w.error_code  = err;
    w.last        = 1'b0;
    step_words.push_back(w);
  endfunction

  function automatic void reset_row();
    ph       = PH_OPEN;
    has_text = 1'b0;
    cr_held  = 1'b0;
    lf_skip  = 1'b0;
    fld_cnt  = 8'd0;
  endfunction

  function automatic void close_field(logic row);
    put_word(8'd0, 1'b0, 1'b1, row, ERR_NONE);
    if (row) fld_cnt = 8'd0;
    else if (fld_cnt < FIELD_CAP) fld_cnt = fld_cnt + 8'd1;
    ph       = PH_OPEN;
    has_text = 1'b0;
  endfunction

  function automatic void flag_error(logic [1:0] code);
    put_word(8'd0, 1'b0, 1'b0, 1'b0, code);
    reset_row();
  endfunction

  // One byte through the field parser; literal makes a CR plain data
  function automatic void take_byte(logic [7:0] c, logic literal);
    logic hold, brk;
    hold = !literal && nl_mode == NL_CRLF && c == CH_CR;
    case (nl_mode)
      NL_UNIVERSAL: brk = (c == CH_CR) || (c == CH_LF);
      NL_LF:        brk = (c == CH_LF);
      NL_CR:        brk = (c == CH_CR);
      default:      brk = 1'b0;
    endcase
    brk = brk && !literal;
    if (ph == PH_INQ) begin
      if (c == CH_QUOTE) ph = PH_AFTER;
      else put_word(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
    end else if (c == CH_QUOTE) begin
      if (ph == PH_AFTER) begin
        // doubled quote inside a quoted field
        put_word(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
        ph = PH_INQ;
      end else if (has_text) begin
        flag_error(ERR_TEXT_BEFORE);
      end else begin
        ph = PH_INQ;
      end
    end else if (c == CH_COMMA) begin
      close_field(1'b0);
    end else if (hold) begin
      cr_held = 1'b1;
    end else if (brk) begin
      close_field(1'b1);
      if (nl_mode == NL_UNIVERSAL && c == CH_CR) lf_skip = 1'b1;
    end else if (ph == PH_AFTER) begin
      flag_error(ERR_TEXT_AFTER);
    end else begin
      put_word(c, 1'b1, 1'b0, 1'b0, ERR_NONE);
      has_text = 1'b1;
    end
  endfunction

  // Expected result words for one accepted input word
  function automatic void tokenize_word(csv_word_t w);
    logic swallow;
    step_words.delete();
    swallow = 1'b0;
    if (w.command == CMD_CHAR) begin
      if (lf_skip) begin
        lf_skip = 1'b0;
        swallow = (w.code == CH_LF);
      end
      if (!swallow) begin
        if (cr_held) begin
          cr_held = 1'b0;
          if (w.code == CH_LF) begin
            close_field(1'b1);
          end else begin
            take_byte(CH_CR, 1'b1);
            take_byte(w.code, 1'b0);
          end
        end else begin
          take_byte(w.code, 1'b0);
        end
      end
    end else begin
      lf_skip = 1'b0;
      if (cr_held) begin
        cr_held = 1'b0;
        take_byte(CH_CR, 1'b1);
      end
      if (fld_cnt != 8'd0 || ph == PH_INQ) flag_error(ERR_UNEXP_END);
      else reset_row();
    end
    if (step_words.size() != 0) step_words[step_words.size() - 1].last = 1'b1;
    foreach (step_words[i]) pending_results.push_back(step_words[i]);
  endfunction

  // ---------------------------------------------------------------- stimulus

  function automatic void push_char(logic [7:0] c);
    char_feed.push_back('{command: CMD_CHAR, code: c});
  endfunction

  function automatic void push_eod();
    char_feed.push_back('{command: CMD_EOD, code: 8'($urandom)});
  endfunction

  function automatic void push_text(string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i]);
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255));
    while (c == CH_QUOTE || c == CH_COMMA || c == CH_CR || c == CH_LF);
    return c;
  endfunction

  // Row ending: 0 CR, 1 LF, 2 CRLF
  function automatic void push_line_end(int style);
    if (style != 1) push_char(CH_CR);
    if (style != 0) push_char(CH_LF);
  endfunction

  // One mostly well-formed row with random content, sometimes followed by noise
  function automatic void gen_row();
    int nf, kind, len, tail, style;
    nf = $urandom_range(1, 5);
    for (int f = 0; f < nf; f++) begin
      if (f != 0) push_char(CH_COMMA);
      kind = $urandom_range(0, 3);
      len  = $urandom_range(1, 4);
      if (kind == 1) begin
        repeat (len) push_char(plain_byte());
      end else if (kind >= 2) begin
        push_char(CH_QUOTE);
        repeat (len) begin
          case ($urandom_range(0, 5))
            0: push_char(CH_COMMA);
            1: push_char(CH_CR);
            2: push_char(CH_LF);
            3: begin
              push_char(CH_QUOTE);
              push_char(CH_QUOTE);
            end
            default: push_char(plain_byte());
          endcase
        end
        push_char(CH_QUOTE);
      end
    end
    tail = $urandom_range(0, 19);
    if (tail == 0) begin
      push_eod();
    end else begin
      case (nl_mode)
        NL_LF:   style = 1;
        NL_CR:   style = 0;
        NL_CRLF: style = 2;
        default: style = $urandom_range(0, 2);
      endcase
      // a foreign row ending now and then
      if (tail < 3) style = $urandom_range(0, 2);
      push_line_end(style);
      if (tail == 3) push_eod();
    end
    if ($urandom_range(0, 6) == 0) begin
      repeat ($urandom_range(1, 4)) begin
        case ($urandom_range(0, 7))
          0: push_eod();
          1: push_char(CH_QUOTE);
          2: push_char(CH_CR);
          3: push_char(CH_LF);
          4: push_char(CH_COMMA);
          default: push_char(8'($urandom));
        endcase
      end
    end
  endfunction

  // APB write: setup cycle, then access until pready
  task automatic write_reg(input logic [2:0] addr, input logic [31:0] val);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == MODE_ADDR) nl_mode = val[1:0];
  endtask

  // Wait until every word is sent and every result has come back
  task automatic settle();
    do @(posedge clk);
    while (char_feed.size() != 0 || in_valid || pending_results.size() != 0);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  initial begin
    logic [1:0] mode;
    reset_row();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // Directed, universal mode: quoted comma, LF and doubled quote, CR then
    // swallowed LF, extreme bytes, both quote errors, end of data mid-row
    // and inside an open quote
    push_char(8'h00);
    push_text(",\"b\"\",\n\",");
    push_char(8'hFF);
    push_char(CH_CR);
    push_char(CH_LF);
    push_text("x\"");
    push_text("\"q\"z");
    push_text(",");
    push_eod();
    push_char(CH_QUOTE);
    push_eod();
    settle();

    // CRLF mode: lone CR turns into data, CRLF ends the row, a CR stays held
    write_reg(MODE_ADDR, 32'(NL_CRLF));
    push_char(CH_CR);
    push_text("z");
    push_char(CH_CR);
    push_char(CH_LF);
    push_char(CH_CR);
    settle();

    // held CR resolved as data after the mode has changed
    write_reg(MODE_ADDR, 32'(NL_UNIVERSAL));
    push_eod();
    settle();

    // Random rows, one mode per phase; phase 2 runs without idling
    for (int p = 0; p < 8; p++) begin
      in_idle_pct   = (p == 2) ? 0 : 35;
      out_stall_pct = (p == 2) ? 0 : 35;
      mode = (p < 7) ? mode_seq[p] : 2'($urandom);
      write_reg(MODE_ADDR, ($urandom & 32'hFFFF_FFFC) | 32'(mode));
      while (char_feed.size() < 120) gen_row();
      // one row long enough to saturate the field index
      if (p == 0) begin
        repeat (300) push_char(CH_COMMA);
        push_char(CH_LF);
      end
      settle();
    end

    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // ---------------------------------------------------------------- driver

  always @(posedge clk) begin : drive_words
    logic taken;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      taken = in_valid && !in_stall;
      if (taken) begin
        tokenize_word('{command: in_command, code: in_char_code});
        void'(char_feed.pop_front());
      end
      if (in_valid && !taken) begin
        // stalled: hold the word
      end else if (char_feed.size() != 0 && $urandom_range(0, 99) >= in_idle_pct) begin
        in_valid     <= 1'b1;
        in_command   <= char_feed[0].command;
        in_char_code <= char_feed[0].code;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------- monitor

  always @(posedge clk) begin : check_results
    csvt_res_t got, want;
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(0, 99) < out_stall_pct);
      if (out_valid && !out_stall) begin
        got = '{out_data_char, out_char_valid, out_field_end, out_row_end,
                out_field_index, out_error_code, out_last};
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected result word: char %h v%b fe%b re%b idx %0d err %0d last %b",
                     got.data_char, got.char_valid, got.field_end, got.row_end,
                     got.field_index, got.error_code, got.last);
        end else begin
          want = pending_results.pop_front();
          if (got.data_char !== want.data_char || got.char_valid !== want.char_valid ||
              got.field_end !== want.field_end || got.row_end !== want.row_end ||
              got.field_index !== want.field_index ||
              got.error_code !== want.error_code || got.last !== want.last) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch expected: char %h v%b fe%b re%b idx %0d err %0d last %b",
                       want.data_char, want.char_valid, want.field_end, want.row_end,
                       want.field_index, want.error_code, want.last);
              $display("         actual:   char %h v%b fe%b re%b idx %0d err %0d last %b",
                       got.data_char, got.char_valid, got.field_end, got.row_end,
                       got.field_index, got.error_code, got.last);
            end
          end
        end
      end
    end
  end

  // Watchdog: too long with no word moving on any port
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule

>>> sim.f
src/csvt_pkg.sv
src/csvt_front.sv
src/csvt_queue.sv
src/csvt_back.sv
src/csv_field_tokenizer.sv
dv/csv_field_tokenizer_test.sv
